// ===== src/rked_pkg.sv =====
// rked_pkg: shared types, widths and event codes of the rotary knob event decoder
// no dependencies; used by the interfaces and every module of the block
package rked_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CODE_W  = 4;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned SPD_W   = 7;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned ACC_W   = 8;
  localparam int unsigned PEND_W  = 2;
  localparam int unsigned NRES_W  = 2;

  // half of the wrapping millisecond range
  localparam logic [TIME_W-1:0] HALF_RANGE = 32'h8000_0000;

  // event codes
  localparam logic [CODE_W-1:0] EV_CW      = 4'd0;
  localparam logic [CODE_W-1:0] EV_CCW     = 4'd1;
  localparam logic [CODE_W-1:0] EV_FAST    = 4'd2;
  localparam logic [CODE_W-1:0] EV_PRESSED = 4'd4;
  localparam logic [CODE_W-1:0] EV_SHORT   = 4'd8;
  localparam logic [CODE_W-1:0] EV_LONG    = 4'd9;
  localparam logic [CODE_W-1:0] EV_DOUBLE  = 4'd10;
  localparam logic [CODE_W-1:0] EV_TRIPLE  = 4'd11;

  // input function codes
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_FLUSH  = 1'b1;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_SW_DB     = 3'd0;
  localparam logic [CIDX_W-1:0] REG_CLK_DB    = 3'd1;
  localparam logic [CIDX_W-1:0] REG_LONG      = 3'd2;
  localparam logic [CIDX_W-1:0] REG_WINDOW    = 3'd3;
  localparam logic [CIDX_W-1:0] REG_FAST_IN   = 3'd4;
  localparam logic [CIDX_W-1:0] REG_FAST_OUT  = 3'd5;
  localparam logic [CIDX_W-1:0] REG_SPD       = 3'd6;
  localparam logic [CIDX_W-1:0] REG_EDGE_MODE = 3'd7;

  typedef struct packed {
    logic [CFG_W-1:0]  sw_db;
    logic [CFG_W-1:0]  clk_db;
    logic [CFG_W-1:0]  long_ms;
    logic [CFG_W-1:0]  window_ms;
    logic [CFG_W-1:0]  fast_in_ms;
    logic [CFG_W-1:0]  fast_out_ms;
    logic [SPD_W-1:0]  spd;
    logic [MODE_W-1:0] edge_mode;
  } rked_cfg_t;

  // results of one decoded item, switch event first
  typedef struct packed {
    logic [NRES_W-1:0] cnt;
    logic [CODE_W-1:0] code0;
    logic [CODE_W-1:0] code1;
  } rked_res_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
  } rked_beat_t;

endpackage

// ===== src/rked_in_if.sv =====
// rked_in_if: input channel of the knob decoder, pin samples or flush polls
// depends on rked_pkg for field widths
interface rked_in_if;
  import rked_pkg::*;

  logic              valid;
  logic              ready;
  logic              func;
  logic              clk_level;
  logic              dt_level;
  logic              sw_level;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, func, clk_level, dt_level, sw_level, now_ms, input ready);
  modport sink   (input valid, func, clk_level, dt_level, sw_level, now_ms, output ready);
endinterface

// ===== src/rked_out_if.sv =====
// rked_out_if: result channel of the knob decoder, one event per beat
// depends on rked_pkg for field widths
interface rked_out_if;
  import rked_pkg::*;

  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] event_code;
  logic              last_of_run;

  modport source (output valid, event_code, last_of_run, input ready);
  modport sink   (input valid, event_code, last_of_run, output ready);
endinterface

// ===== src/rotary_knob_event_decoder.sv =====
// Rotary knob event decoder: debounced turn and press events from pin samples.
// Results of an item pass the input register, then the result buffer, before they are offered.
// Throughput: one item per cycle while the result buffer has room; an item with two
// events takes both entries of the two-entry buffer, which drains one beat a cycle when ready.
// Reset: synchronous rst_n restores register defaults and idle knob state at once.
// Depends on rked_pkg, rked_in_if, rked_out_if, rked_cfg, rked_core, rked_outq.
module rotary_knob_event_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [rked_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [rked_pkg::CFG_W-1:0]    cfg_wdata,
  rked_in_if.sink                       in_item,
  rked_out_if.source                    out_evt
);
  import rked_pkg::*;

  rked_cfg_t         cfg;
  rked_res_t         res;
  logic              push;
  logic [NRES_W-1:0] room;

  // configuration registers
  rked_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  // decode stage
  rked_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_item),
    .cfg     (cfg),
    .room    (room),
    .push    (push),
    .res     (res)
  );

  // result buffer
  rked_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .res     (res),
    .room    (room),
    .out_evt (out_evt)
  );

  // a beat that is not last is a switch event followed at once by a turn event
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_evt.valid && out_evt.ready && !out_evt.last_of_run) |->
      (out_evt.event_code >= EV_SHORT) ##1 (out_evt.valid && out_evt.event_code < EV_SHORT))
    else $error("switch event not followed by its turn event");

  // turn events always close their run
  a_turn_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_evt.valid && out_evt.event_code < EV_SHORT) |-> out_evt.last_of_run)
    else $error("turn event without last_of_run");

  // decoded results never exceed the buffer space
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (res.cnt <= room && room <= NRES_W'(2)))
    else $error("result buffer overflow");

endmodule

// ===== src/rked_cfg.sv =====
// rked_cfg: configuration register bank of the knob decoder
// depends on rked_pkg for register indexes and the config struct
module rked_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [rked_pkg::CIDX_W-1:0]   index,
  input  logic [rked_pkg::CFG_W-1:0]    wdata,
  output rked_pkg::rked_cfg_t           cfg
);
  import rked_pkg::*;

  rked_cfg_t cfg_r;

  // register writes, reset to the power-on timings
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sw_db       <= 16'd20;
      cfg_r.clk_db      <= 16'd2;
      cfg_r.long_ms     <= 16'd800;
      cfg_r.window_ms   <= 16'd300;
      cfg_r.fast_in_ms  <= 16'd40;
      cfg_r.fast_out_ms <= 16'd120;
      cfg_r.spd         <= 7'd1;
      cfg_r.edge_mode   <= 2'd0;
    end else if (wr_en) begin
      unique case (index)
        REG_SW_DB:     cfg_r.sw_db       <= wdata;
        REG_CLK_DB:    cfg_r.clk_db      <= wdata;
        REG_LONG:      cfg_r.long_ms     <= wdata;
        REG_WINDOW:    cfg_r.window_ms   <= wdata;
        REG_FAST_IN:   cfg_r.fast_in_ms  <= wdata;
        REG_FAST_OUT:  cfg_r.fast_out_ms <= wdata;
        REG_SPD:       cfg_r.spd         <= wdata[SPD_W-1:0];
        REG_EDGE_MODE: cfg_r.edge_mode   <= wdata[MODE_W-1:0];
        default:       cfg_r             <= cfg_r;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/rked_core.sv =====
// rked_core: input register, knob state and single-pass event decode
// depends on rked_pkg and rked_in_if; hands decoded results to the result buffer
module rked_core (
  input  logic                          clk,
  input  logic                          rst_n,
  rked_in_if.sink                       in_item,
  input  rked_pkg::rked_cfg_t           cfg,
  input  logic [rked_pkg::NRES_W-1:0]   room,
  output logic                          push,
  output rked_pkg::rked_res_t           res
);
  import rked_pkg::*;

  // input register
  logic              iv_r;
  logic              func_r, clkl_r, dtl_r, swl_r;
  logic [TIME_W-1:0] now_r;

  // knob state
  logic               prev_sw_r, prev_sw_nxt;
  logic               prev_clk_r, prev_clk_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [TIME_W-1:0]  ldt_r, ldt_nxt;
  logic               fast_r, fast_nxt;
  logic [TIME_W-1:0]  pst_r, pst_nxt;
  logic               down_r, down_nxt;
  logic               twd_r, twd_nxt;
  logic [TIME_W-1:0]  lcet_r, lcet_nxt;
  logic [TIME_W-1:0]  lset_r, lset_nxt;
  logic [PEND_W-1:0]  pend_r, pend_nxt;
  logic [TIME_W-1:0]  dl_r, dl_nxt;

  // decode temporaries
  logic               flush_ok;
  logic               sw_edge, clk_edge, skip_clock;
  logic [TIME_W-1:0]  held;
  logic [PEND_W-1:0]  pend_tmp;
  logic [PEND_W:0]    pend_inc;
  logic               sw_ev, turn_ev;
  logic [CODE_W-1:0]  sw_code, turn_code;
  logic               step_pos;
  logic signed [ACC_W:0] acc_sum, spd_s;
  logic               detent, cw;
  logic [TIME_W-1:0]  gap;
  logic               accept, proc;

  // a flush needs a live deadline that has been reached
  assign flush_ok = (pend_r != '0) && (dl_r != '0) &&
                    ((now_r - dl_r) < HALF_RANGE) && (now_r >= dl_r);

  assign sw_edge = (func_r == FUNC_SAMPLE) && (swl_r != prev_sw_r) &&
                   ((lset_r == '0) || ((now_r - lset_r) >= {16'd0, cfg.sw_db}));

  assign held     = (pst_r != '0) ? (now_r - pst_r) : '0;
  assign step_pos = clkl_r ^ dtl_r ^ cfg.edge_mode[1];
  assign spd_s    = signed'({2'b00, cfg.spd});
  assign acc_sum  = signed'({acc_r[ACC_W-1], acc_r}) + (step_pos ? 9'sd1 : -9'sd1);
  assign detent   = (acc_sum >= spd_s) || (acc_sum <= -spd_s);
  assign cw       = acc_sum > 9'sd0;
  assign gap      = now_r - ldt_r;

  // flush polls, or switch and press handling followed by clock and detent handling
  always_comb begin
    prev_sw_nxt  = prev_sw_r;
    prev_clk_nxt = prev_clk_r;
    acc_nxt      = acc_r;
    ldt_nxt      = ldt_r;
    fast_nxt     = fast_r;
    pst_nxt      = pst_r;
    down_nxt     = down_r;
    twd_nxt      = twd_r;
    lcet_nxt     = lcet_r;
    lset_nxt     = lset_r;
    pend_nxt     = pend_r;
    dl_nxt       = dl_r;
    skip_clock   = 1'b0;
    sw_ev        = 1'b0;
    sw_code      = EV_SHORT;
    turn_ev      = 1'b0;
    turn_code    = EV_CW;
    pend_tmp     = pend_r;
    pend_inc     = '0;
    clk_edge     = 1'b0;

    if (func_r == FUNC_FLUSH) begin
      if (flush_ok) begin
        sw_ev    = (pend_r == 2'd1) || (pend_r == 2'd2);
        sw_code  = (pend_r == 2'd1) ? EV_SHORT : EV_DOUBLE;
        pend_nxt = '0;
        dl_nxt   = '0;
      end
    end else begin
      if (sw_edge) begin
        lset_nxt = now_r;
        if (!swl_r) begin
          pst_nxt  = now_r;
          down_nxt = 1'b1;
          twd_nxt  = 1'b0;
        end else begin
          down_nxt = 1'b0;
          pst_nxt  = '0;
          twd_nxt  = 1'b0;
          if (twd_r) begin
            pend_nxt   = '0;
            dl_nxt     = '0;
            skip_clock = 1'b1;
          end else if (held >= {16'd0, cfg.long_ms}) begin
            pend_nxt = '0;
            dl_nxt   = '0;
            sw_ev    = 1'b1;
            sw_code  = EV_LONG;
          end else begin
            // an overdue earlier press resolves before this one counts
            if (flush_ok) begin
              sw_ev    = (pend_r == 2'd1) || (pend_r == 2'd2);
              sw_code  = (pend_r == 2'd1) ? EV_SHORT : EV_DOUBLE;
              pend_tmp = '0;
            end
            dl_nxt   = now_r + {16'd0, cfg.window_ms};
            pend_inc = {1'b0, pend_tmp} + 3'd1;
            if (pend_inc >= 3'd3) begin
              sw_ev    = 1'b1;
              sw_code  = EV_TRIPLE;
              pend_nxt = '0;
              dl_nxt   = '0;
            end else begin
              pend_nxt = pend_inc[PEND_W-1:0];
            end
          end
        end
      end

      clk_edge = !skip_clock && (clkl_r != prev_clk_r) &&
                 ((lcet_r == '0) || ((now_r - lcet_r) >= {16'd0, cfg.clk_db}));
      if (clk_edge) begin
        lcet_nxt = now_r;
        if (clkl_r == cfg.edge_mode[0]) begin
          acc_nxt = acc_sum[ACC_W-1:0];
          if (detent) begin
            acc_nxt = '0;
            if (ldt_r != '0) begin
              if (gap <= {16'd0, cfg.fast_in_ms}) begin
                fast_nxt = 1'b1;
              end else if (gap >= {16'd0, cfg.fast_out_ms}) begin
                fast_nxt = 1'b0;
              end
            end
            ldt_nxt = now_r;
            if (down_nxt) twd_nxt = 1'b1;
            turn_ev   = 1'b1;
            turn_code = (cw ? EV_CW : EV_CCW) | (fast_nxt ? EV_FAST : EV_CW) |
                        (down_nxt ? EV_PRESSED : EV_CW);
          end
        end
      end
      prev_sw_nxt  = swl_r;
      prev_clk_nxt = clkl_r;
    end
  end

  // result bundle, switch event ahead of turn event
  always_comb begin
    res.cnt   = NRES_W'({1'b0, sw_ev} + {1'b0, turn_ev});
    res.code0 = sw_ev ? sw_code : turn_code;
    res.code1 = turn_code;
  end

  // an item without events commits its state but writes nothing to the buffer
  assign proc          = iv_r && (res.cnt <= room);
  assign push          = proc && (res.cnt != '0);
  assign in_item.ready = !iv_r || proc;
  assign accept        = in_item.valid && in_item.ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (accept) begin
      iv_r <= 1'b1;
    end else if (proc) begin
      iv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_item.func;
      clkl_r <= in_item.clk_level;
      dtl_r  <= in_item.dt_level;
      swl_r  <= in_item.sw_level;
      now_r  <= in_item.now_ms;
    end
  end

  // knob state commits when the item is processed, as its results enter the buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_sw_r  <= 1'b1;
      prev_clk_r <= 1'b0;
      acc_r      <= '0;
      ldt_r      <= '0;
      fast_r     <= 1'b0;
      pst_r      <= '0;
      down_r     <= 1'b0;
      twd_r      <= 1'b0;
      lcet_r     <= '0;
      lset_r     <= '0;
      pend_r     <= '0;
      dl_r       <= '0;
    end else if (proc) begin
      prev_sw_r  <= prev_sw_nxt;
      prev_clk_r <= prev_clk_nxt;
      acc_r      <= acc_nxt;
      ldt_r      <= ldt_nxt;
      fast_r     <= fast_nxt;
      pst_r      <= pst_nxt;
      down_r     <= down_nxt;
      twd_r      <= twd_nxt;
      lcet_r     <= lcet_nxt;
      lset_r     <= lset_nxt;
      pend_r     <= pend_nxt;
      dl_r       <= dl_nxt;
    end
  end

endmodule

// ===== src/rked_outq.sv =====
// rked_outq: two-entry result buffer that drives the event channel
// depends on rked_pkg and rked_out_if; fed by rked_core
module rked_outq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  rked_pkg::rked_res_t           res,
  output logic [rked_pkg::NRES_W-1:0]   room,
  rked_out_if.source                    out_evt
);
  import rked_pkg::*;

  rked_beat_t        q0_r, q1_r, q0_nxt, q1_nxt, new0, new1;
  logic [NRES_W-1:0] cnt_r, cnt_nxt, cnt_a;
  logic              pop;

  assign pop   = (cnt_r != '0) && out_evt.ready;
  assign cnt_a = cnt_r - NRES_W'(pop);
  assign room  = NRES_W'(2) - cnt_a;

  assign new0 = '{code: res.code0, last: (res.cnt == 2'd1)};
  assign new1 = '{code: res.code1, last: 1'b1};

  // shift out the head beat, then append the new results
  always_comb begin
    q0_nxt  = pop ? q1_r : q0_r;
    q1_nxt  = q1_r;
    cnt_nxt = cnt_a;
    if (push) begin
      cnt_nxt = cnt_a + res.cnt;
      if (cnt_a == '0) begin
        q0_nxt = new0;
        q1_nxt = new1;
      end else begin
        q1_nxt = new0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  assign out_evt.valid       = cnt_r != '0;
  assign out_evt.event_code  = q0_r.code;
  assign out_evt.last_of_run = q0_r.last;

endmodule

// ===== tb/rotary_knob_event_decoder_test.sv =====
`timescale 1ns / 100ps
// rotary_knob_event_decoder_test: self-checking bench for the knob event decoder,
// with a directed opening, random pin traffic over several register settings and a scoreboard
// depends on rked_pkg, rked_in_if, rked_out_if and rotary_knob_event_decoder
module rotary_knob_event_decoder_test;
  import rked_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int PHASE_ITEMS     = 110;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_LIMIT     = 2000;
  localparam int TAIL_CYCLES     = 4;

  // mirror of the decoder: registers, knob state and the events still owed
  class knob_event_tracker;
    rked_cfg_t         regs;
    logic              prev_sw, prev_clk, sw_down, turned_down, fast_on;
    int                step_acc;
    logic [TIME_W-1:0] last_detent_t, press_t, last_clk_edge_t, last_sw_edge_t, deadline;
    logic [PEND_W-1:0] presses;
    logic [CODE_W-1:0] run_code[2];
    int                run_len;
    rked_beat_t        due_events[$];
    int                errors;

    function new();
      regs.sw_db       = 16'd20;
      regs.clk_db      = 16'd2;
      regs.long_ms     = 16'd800;
      regs.window_ms   = 16'd300;
      regs.fast_in_ms  = 16'd40;
      regs.fast_out_ms = 16'd120;
      regs.spd         = 7'd1;
      regs.edge_mode   = 2'd0;
      prev_sw = 1'b1;
      prev_clk = 1'b0;
      sw_down = 1'b0;
      turned_down = 1'b0;
      fast_on = 1'b0;
      step_acc = 0;
      last_detent_t = '0;
      press_t = '0;
      last_clk_edge_t = '0;
      last_sw_edge_t = '0;
      deadline = '0;
      presses = '0;
      run_len = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_SW_DB:     regs.sw_db = val;
        REG_CLK_DB:    regs.clk_db = val;
        REG_LONG:      regs.long_ms = val;
        REG_WINDOW:    regs.window_ms = val;
        REG_FAST_IN:   regs.fast_in_ms = val;
        REG_FAST_OUT:  regs.fast_out_ms = val;
        REG_SPD:       regs.spd = val[SPD_W-1:0];
        REG_EDGE_MODE: regs.edge_mode = val[MODE_W-1:0];
        default: ;
      endcase
    endfunction

    function void add_event(logic [CODE_W-1:0] code);
      if (run_len < 2) begin
        run_code[run_len] = code;
        run_len++;
      end
    endfunction

    // resolve a pending short or double press once its deadline has gone by
    function void flush_presses(logic [TIME_W-1:0] t_ms);
      logic [TIME_W-1:0] since;
      since = t_ms - deadline;
      if (presses == 0 || deadline == 0 || since >= HALF_RANGE || t_ms < deadline) return;
      if (presses == 1) add_event(EV_SHORT);
      else if (presses == 2) add_event(EV_DOUBLE);
      presses = '0;
      deadline = '0;
    endfunction

    function void note_item(logic func, logic clk_l, logic dt_l, logic sw_l,
                            logic [TIME_W-1:0] t_ms);
      logic              skip_turn;
      logic [TIME_W-1:0] held, gap, since_sw, since_clk;
      int                step, spd;
      logic [CODE_W-1:0] code;
      rked_beat_t        beat;
      run_len = 0;
      skip_turn = 1'b0;
      if (func == FUNC_FLUSH) begin
        flush_presses(t_ms);
      end else begin
        // switch edge, debounced
        since_sw = t_ms - last_sw_edge_t;
        if (sw_l != prev_sw && (last_sw_edge_t == 0 || since_sw >= regs.sw_db)) begin
          last_sw_edge_t = t_ms;
          if (!sw_l) begin
            press_t = t_ms;
            sw_down = 1'b1;
            turned_down = 1'b0;
          end else begin
            held = (press_t != 0) ? t_ms - press_t : '0;
            sw_down = 1'b0;
            press_t = '0;
            if (turned_down) begin
              // a turn while held swallows the press and this item's clock edge
              presses = '0;
              deadline = '0;
              skip_turn = 1'b1;
            end else if (held >= regs.long_ms) begin
              presses = '0;
              deadline = '0;
              add_event(EV_LONG);
            end else begin
              if (presses != 0 && deadline != 0 && t_ms >= deadline) flush_presses(t_ms);
              deadline = t_ms + regs.window_ms;
              presses = presses + 1'b1;
              if (presses >= 3) begin
                add_event(EV_TRIPLE);
                presses = '0;
                deadline = '0;
              end
            end
            turned_down = 1'b0;
          end
        end
        // clock edge, debounced, counted on the selected level only
        since_clk = t_ms - last_clk_edge_t;
        if (!skip_turn && clk_l != prev_clk &&
            (last_clk_edge_t == 0 || since_clk >= regs.clk_db)) begin
          last_clk_edge_t = t_ms;
          if (clk_l == regs.edge_mode[0]) begin
            step = (clk_l ^ dt_l) ? 1 : -1;
            if (regs.edge_mode[1]) step = -step;
            step_acc += step;
            spd = regs.spd;
            if (step_acc >= spd || step_acc <= -spd) begin
              code = (step_acc > 0) ? EV_CW : EV_CCW;
              step_acc = 0;
              // fast mode hysteresis on detent spacing
              if (last_detent_t != 0) begin
                gap = t_ms - last_detent_t;
                if (gap <= regs.fast_in_ms) fast_on = 1'b1;
                else if (gap >= regs.fast_out_ms) fast_on = 1'b0;
              end
              last_detent_t = t_ms;
              if (sw_down) turned_down = 1'b1;
              if (fast_on) code = code | EV_FAST;
              if (sw_down) code = code | EV_PRESSED;
              add_event(code);
            end
          end
        end
        prev_sw = sw_l;
        prev_clk = clk_l;
      end
      for (int i = 0; i < run_len; i++) begin
        beat.code = run_code[i];
        beat.last = (i == run_len - 1);
        due_events.push_back(beat);
      end
    endfunction

    function void check_event(logic [CODE_W-1:0] code, logic last);
      rked_beat_t want;
      if (due_events.size() == 0) begin
        $error("event_code: expected no event, got %0d", code);
        errors++;
        return;
      end
      want = due_events.pop_front();
      if (code !== want.code) begin
        $error("event_code: expected %0d, got %0d", want.code, code);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %0d, got %0d", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;

  rked_in_if  in_if();
  rked_out_if out_if();

  knob_event_tracker tracker;

  // pin levels and time as last offered, plus idling state of both sides
  logic              cur_clk, cur_dt, cur_sw, turn_dir;
  logic [TIME_W-1:0] tb_now;
  int                send_burst, recv_burst, beats_taken;
  bit                held_off;

  rotary_knob_event_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_if),
    .out_evt   (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // beats seen at the rising edge: inputs feed the mirror, results are checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        tracker.note_item(in_if.func, in_if.clk_level, in_if.dt_level, in_if.sw_level,
                          in_if.now_ms);
      if (out_if.valid && out_if.ready)
        tracker.check_event(out_if.event_code, out_if.last_of_run);
    end
  end

  // result side: random stalls, idle-free stretches and one long hold-off
  initial begin
    int stall;
    out_if.ready = 1'b0;
    recv_burst = 0;
    beats_taken = 0;
    held_off = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held_off && beats_taken >= 50) begin
        stall = HOLD_OFF_CYCLES;
        held_off = 1'b1;
      end else if (recv_burst > 0) begin
        stall = 0;
        recv_burst--;
      end else if ($urandom_range(0, 15) == 0) begin
        stall = 0;
        recv_burst = $urandom_range(10, 40);
      end else begin
        stall = $urandom_range(0, 12);
      end
      @(negedge clk);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      beats_taken++;
    end
  end

  // offer one beat after a random gap and hold it until taken
  task automatic send_item(input logic f, c, d, s, input logic [TIME_W-1:0] t);
    int gap;
    if (send_burst > 0) begin
      gap = 0;
      send_burst--;
    end else if ($urandom_range(0, 15) == 0) begin
      gap = 0;
      send_burst = $urandom_range(10, 40);
    end else begin
      gap = $urandom_range(0, 12);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.func      <= f;
    in_if.clk_level <= c;
    in_if.dt_level  <= d;
    in_if.sw_level  <= s;
    in_if.now_ms    <= t;
    do @(posedge clk); while (!in_if.ready);
    if (f == FUNC_SAMPLE) begin
      cur_clk = c;
      cur_dt = d;
      cur_sw = s;
    end
    tb_now = t;
  endtask

  task automatic load_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_reg(idx, val);
  endtask

  task automatic apply_settings(input logic [CFG_W-1:0] sw_db, clk_db, long_ms, window_ms,
                                fast_in, fast_out, spd, mode);
    load_reg(REG_SW_DB, sw_db);
    load_reg(REG_CLK_DB, clk_db);
    load_reg(REG_LONG, long_ms);
    load_reg(REG_WINDOW, window_ms);
    load_reg(REG_FAST_IN, fast_in);
    load_reg(REG_FAST_OUT, fast_out);
    load_reg(REG_SPD, spd);
    load_reg(REG_EDGE_MODE, mode);
  endtask

  // stop offering, wait for owed events, then let the pipe empty
  task automatic settle();
    int waited;
    waited = 0;
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (tracker.due_events.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // mostly short steps, some long holds and the odd jump anywhere in the range
  function automatic logic [TIME_W-1:0] time_step(int stretch);
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom_range(0, 6) * stretch;
    if (r < 80) return $urandom_range(0, 60) * stretch;
    if (r < 96) return $urandom_range(100, 1200) * stretch;
    return $urandom();
  endfunction

  // one random item: turns in a running direction, switch toggles, polls, noise
  task automatic random_item(input int stretch, output bit counts);
    int   pick;
    logic f, c, d, s;
    logic [2:0] pins;
    pick = $urandom_range(0, 99);
    f = FUNC_SAMPLE;
    c = cur_clk;
    d = cur_dt;
    s = cur_sw;
    counts = 1'b1;
    if (pick < 45) begin
      if ($urandom_range(0, 9) == 0) turn_dir = ~turn_dir;
      c = ~cur_clk;
      d = c ^ turn_dir;
    end else if (pick < 62) begin
      s = ~cur_sw;
    end else if (pick < 75) begin
      f = FUNC_FLUSH;
      pins = 3'($urandom_range(0, 7));
      {c, d, s} = pins;
    end else if (pick < 88) begin
      pins = 3'($urandom_range(0, 7));
      {c, d, s} = pins;
    end else begin
      counts = 1'b0;
    end
    send_item(f, c, d, s, tb_now + time_step(stretch));
  endtask

  initial begin
    int p, stretch, counted;
    bit took;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_SW_DB;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.func = FUNC_SAMPLE;
    in_if.clk_level = 1'b0;
    in_if.dt_level = 1'b0;
    in_if.sw_level = 1'b1;
    in_if.now_ms = '0;
    cur_clk = 1'b0;
    cur_dt = 1'b0;
    cur_sw = 1'b1;
    turn_dir = 1'b0;
    tb_now = '0;
    send_burst = 0;
    tracker = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed opening on reset settings
    // press at time zero counts as held for nothing, so a late release is short
    send_item(FUNC_SAMPLE, 1'b0, 1'b0, 1'b1, 32'd0);
    send_item(FUNC_SAMPLE, 1'b0, 1'b1, 1'b0, 32'd0);
    send_item(FUNC_SAMPLE, 1'b0, 1'b0, 1'b1, 32'd900);
    send_item(FUNC_FLUSH,  1'b1, 1'b1, 1'b0, 32'd1200);
    // clock edges too close to the last one are debounced away, then a first detent
    send_item(FUNC_SAMPLE, 1'b1, 1'b0, 1'b1, 32'd1201);
    send_item(FUNC_SAMPLE, 1'b0, 1'b1, 1'b1, 32'd1202);
    send_item(FUNC_SAMPLE, 1'b1, 1'b1, 1'b1, 32'd1203);
    send_item(FUNC_SAMPLE, 1'b0, 1'b0, 1'b1, 32'd1204);
    send_item(FUNC_SAMPLE, 1'b1, 1'b0, 1'b1, 32'd1205);
    send_item(FUNC_SAMPLE, 1'b0, 1'b1, 1'b1, 32'd1400);
    // long press released together with a detent: two events from one item
    send_item(FUNC_SAMPLE, 1'b1, 1'b0, 1'b0, 32'd1500);
    send_item(FUNC_SAMPLE, 1'b0, 1'b1, 1'b1, 32'd2400);
    // turn while held, then the release swallows the press and its clock edge
    send_item(FUNC_SAMPLE, 1'b1, 1'b0, 1'b0, 32'd2500);
    send_item(FUNC_SAMPLE, 1'b0, 1'b0, 1'b0, 32'd2510);
    send_item(FUNC_SAMPLE, 1'b1, 1'b0, 1'b1, 32'd2600);
    // triple press
    send_item(FUNC_SAMPLE, 1'b1, 1'b1, 1'b0, 32'd2700);
    send_item(FUNC_SAMPLE, 1'b1, 1'b0, 1'b1, 32'd2730);
    send_item(FUNC_SAMPLE, 1'b1, 1'b1, 1'b0, 32'd2760);
    send_item(FUNC_SAMPLE, 1'b1, 1'b0, 1'b1, 32'd2790);
    send_item(FUNC_SAMPLE, 1'b1, 1'b1, 1'b0, 32'd2820);
    send_item(FUNC_SAMPLE, 1'b1, 1'b0, 1'b1, 32'd2850);
    // deadline wraps to zero: no flush, a later short release makes a double
    send_item(FUNC_SAMPLE, 1'b1, 1'b0, 1'b0, 32'hFFFF_FE00);
    send_item(FUNC_SAMPLE, 1'b1, 1'b1, 1'b1, 32'hFFFF_FED4);
    send_item(FUNC_FLUSH,  1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
    send_item(FUNC_SAMPLE, 1'b1, 1'b0, 1'b0, 32'h0000_0010);
    send_item(FUNC_SAMPLE, 1'b1, 1'b1, 1'b1, 32'h0000_0040);
    send_item(FUNC_FLUSH,  1'b0, 1'b1, 1'b0, 32'h0000_0200);

    // random phases, each on its own register setting
    for (p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: begin
          apply_settings(16'd20, 16'd2, 16'd800, 16'd300, 16'd40, 16'd120, 16'd1, 16'd0);
          stretch = 1;
          tb_now = 32'd5000;
        end
        1: begin
          // all zero, upper bits set on the narrow registers
          apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFF80, 16'hFFFF);
          stretch = 1;
          tb_now = 32'hFFFF_F000;
        end
        2: begin
          apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'd100, 16'd2);
          stretch = 100;
          tb_now = 32'h0001_0000;
        end
        default: begin
          apply_settings(CFG_W'($urandom_range(5, 30)), CFG_W'($urandom_range(0, 4)),
                         CFG_W'($urandom_range(100, 1000)), CFG_W'($urandom_range(50, 400)),
                         CFG_W'($urandom_range(10, 60)), CFG_W'($urandom_range(60, 200)),
                         CFG_W'($urandom_range(1, 4)), CFG_W'($urandom_range(0, 3)));
          stretch = 1;
          tb_now = $urandom();
        end
      endcase
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        random_item(stretch, took);
        counted += took;
      end
    end

    settle();
    if (tracker.due_events.size() != 0) begin
      $error("event_code: %0d expected events never arrived", tracker.due_events.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== rotary_knob_event_decoder.f =====
src/rked_pkg.sv
src/rked_in_if.sv
src/rked_out_if.sv
src/rked_cfg.sv
src/rked_core.sv
src/rked_outq.sv
src/rotary_knob_event_decoder.sv
tb/rotary_knob_event_decoder_test.sv
